@@ design/kfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfr_pkg
// Shared types, codes and the frame status function for the frame receiver.
// ----------------------------------------------------------------------------
package kfr_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] STATUS_VALID = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd400;
  localparam logic [15:0] GAP_MAX           = 16'hFFFF;

  localparam int unsigned REG_GAP_TIMEOUT = 0;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } res_push_t;

  function automatic logic [1:0] frame_status(input logic [7:0] count,
                                              input logic [7:0] sum,
                                              input logic [7:0] newest);
    logic [7:0] head_sum;
    head_sum = sum - newest;
    if (count == 8'd0) begin
      frame_status = STATUS_EMPTY;
    end else if (count < 8'd2) begin
      frame_status = STATUS_BAD;
    end else if (head_sum == newest || sum == 8'd0) begin
      frame_status = STATUS_VALID;
    end else begin
      frame_status = STATUS_BAD;
    end
  endfunction

endpackage
`default_nettype wire

@@ design/kfr_apb_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfr_apb_regs
// APB-style register port holding the idle gap timeout.
// ----------------------------------------------------------------------------
module kfr_apb_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      gap_timeout_ms
);
  import kfr_pkg::*;

  logic sel_timeout;

  assign sel_timeout = (paddr[2] == 1'(REG_GAP_TIMEOUT));
  assign pready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_timeout_ms <= GAP_TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && sel_timeout) begin
      gap_timeout_ms <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (sel_timeout) begin
      prdata = {16'd0, gap_timeout_ms};
    end
  end

endmodule
`default_nettype wire

@@ design/kfr_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfr_core
// Frame state and per-transaction result logic behind the input register.
// ----------------------------------------------------------------------------
module kfr_core #(
  parameter int unsigned MAX_FRAME = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire logic [1:0]  item_op,
  input  wire logic [7:0]  item_byte,
  input  wire logic [15:0] gap_timeout_ms,
  output kfr_pkg::res_push_t push
);
  import kfr_pkg::*;

  logic        receiving, receiving_next;
  logic        first_seen, first_seen_next;
  logic [7:0]  kept_count, kept_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  newest_byte, newest_byte_next;
  logic [15:0] gap_count, gap_count_next;
  logic [15:0] gap_inc;
  logic        full;

  assign gap_inc = (gap_count == GAP_MAX) ? gap_count : gap_count + 16'd1;
  assign full    = ({1'b0, kept_count} + 9'd1) >= 9'(MAX_FRAME);

  always_comb begin
    receiving_next   = receiving;
    first_seen_next  = first_seen;
    kept_count_next  = kept_count;
    running_sum_next = running_sum;
    newest_byte_next = newest_byte;
    gap_count_next   = gap_count;
    push             = '0;
    if (item_valid) begin
      if (item_op == OP_START) begin
        receiving_next   = 1'b1;
        first_seen_next  = 1'b0;
        kept_count_next  = 8'd0;
        running_sum_next = 8'd0;
        newest_byte_next = 8'd0;
        gap_count_next   = 16'd0;
      end else if (receiving && item_op == OP_TICK) begin
        gap_count_next = gap_inc;
        if (gap_inc >= gap_timeout_ms) begin
          push.push0             = 1'b1;
          push.res0.kind         = KIND_REPORT;
          push.res0.frame_length = kept_count;
          push.res0.status       = frame_status(kept_count, running_sum, newest_byte);
          push.res0.last         = 1'b1;
          receiving_next         = 1'b0;
        end
      end else if (receiving && item_op == OP_BYTE &&
                   (first_seen || item_byte != 8'd0)) begin
        first_seen_next        = 1'b1;
        running_sum_next       = running_sum + item_byte;
        newest_byte_next       = item_byte;
        gap_count_next         = 16'd0;
        kept_count_next        = kept_count + 8'd1;
        push.push0             = 1'b1;
        push.res0.kind         = KIND_DATA;
        push.res0.data_byte    = item_byte;
        push.res0.byte_index   = kept_count;
        push.res0.last         = !full;
        if (full) begin
          push.push1             = 1'b1;
          push.res1.kind         = KIND_REPORT;
          push.res1.frame_length = kept_count_next;
          push.res1.status       = frame_status(kept_count_next, running_sum_next,
                                                item_byte);
          push.res1.last         = 1'b1;
          receiving_next         = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving   <= 1'b0;
      first_seen  <= 1'b0;
      kept_count  <= 8'd0;
      running_sum <= 8'd0;
      newest_byte <= 8'd0;
      gap_count   <= 16'd0;
    end else begin
      receiving   <= receiving_next;
      first_seen  <= first_seen_next;
      kept_count  <= kept_count_next;
      running_sum <= running_sum_next;
      newest_byte <= newest_byte_next;
      gap_count   <= gap_count_next;
    end
  end

endmodule
`default_nettype wire

@@ design/kfr_out_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kfr_out_fifo
// Small result queue taking up to two results per cycle, one out per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module kfr_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire kfr_pkg::res_push_t push,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output kfr_pkg::result_t      head,
  output logic [kfr_pkg::FIFO_CW-1:0] count
);
  import kfr_pkg::*;

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   rd_ptr, wr_ptr, wr_ptr1;
  logic                 pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];
  assign wr_ptr1   = wr_ptr + FIFO_AW'(1);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.push1) begin
      mem[wr_ptr1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      wr_ptr <= wr_ptr + FIFO_AW'(push.push0) + FIFO_AW'(push.push1);
      count  <= count + FIFO_CW'(push.push0) + FIFO_CW'(push.push1) - FIFO_CW'(pop);
    end
  end

endmodule
`default_nettype wire

@@ design/kline_frame_receiver_checksum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kline_frame_receiver_checksum
// Serial frame receiver: keeps bytes, times the idle gap, checks the sum.
// Path: input register, frame core, result queue. Throughput: one input
// transaction per cycle while in_ready is high; a full frame gives two
// results from one transaction, drained through a four-entry result queue.
// Reset: synchronous, clears frame state and queue; timeout returns to 400.
// ----------------------------------------------------------------------------
module kline_frame_receiver_checksum #(
  parameter int unsigned MAX_FRAME = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [7:0]       data_byte,
  output logic [7:0]       byte_index,
  output logic [7:0]       frame_length,
  output logic [1:0]       status,
  output logic             last
);
  import kfr_pkg::*;

  logic [15:0]        gap_timeout_ms;
  logic               s1_valid;
  logic [1:0]         s1_op;
  logic [7:0]         s1_byte;
  res_push_t          push;
  result_t            head;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW:0]   need;
  logic [FIFO_CW:0]   room;

  kfr_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .gap_timeout_ms (gap_timeout_ms)
  );

  // reserve two slots for the staged transaction and two for the new one
  assign need     = {1'b0, count} + (s1_valid ? (FIFO_CW+1)'(2) : '0) + (FIFO_CW+1)'(2);
  assign room     = (FIFO_CW+1)'(FIFO_DEPTH) + (FIFO_CW+1)'(out_valid && out_ready);
  assign in_ready = (need <= room);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op;
      s1_byte <= rx_byte;
    end
  end

  kfr_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (s1_valid),
    .item_op        (s1_op),
    .item_byte      (s1_byte),
    .gap_timeout_ms (gap_timeout_ms),
    .push           (push)
  );

  kfr_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .count     (count)
  );

  assign kind         = head.kind;
  assign data_byte    = head.data_byte;
  assign byte_index   = head.byte_index;
  assign frame_length = head.frame_length;
  assign status       = head.status;
  assign last         = head.last;

endmodule
`default_nettype wire
